[sv/adsr_envelope_generator_assert.svh]
// Assertion macros for the ADSR envelope generator.
// Used by modules that declare clk and rst; no other dependencies.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/adsr_pkg.sv]
// Package for the ADSR envelope generator: item types, register codes,
// divider constants. No dependencies.
package adsr_pkg;

  localparam int QUO_BITS  = 24;             // quotient bits below the cap
  localparam int NUM_BITS  = 2 * QUO_BITS;   // numerator width of the divider
  localparam int DIV_LAT   = QUO_BITS + 1;   // divider register stages
  localparam int CFG_BITS  = 24;             // widest register
  localparam logic [QUO_BITS:0] QUO_CAP = {1'b1, {QUO_BITS{1'b0}}};

  typedef enum logic [2:0] {
    REG_ATTACK    = 3'd0,
    REG_DECAY     = 3'd1,
    REG_RELEASE   = 3'd2,
    REG_START     = 3'd3,
    REG_SUSTAIN   = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] now_tick;
    logic [31:0] press_tick;
    logic [31:0] lift_tick;
  } item_t;

  typedef struct packed {
    logic [15:0] level;
    logic        finished;
  } result_t;

endpackage

[sv/adsr_div.sv]
// Pipelined restoring divider, quotient capped at 2^QUO_BITS, one bit a stage.
// Depends on adsr_pkg.
module adsr_div #(
  parameter int SW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [adsr_pkg::NUM_BITS-1:0]  num,
  input  logic [adsr_pkg::QUO_BITS-1:0]  den,
  input  logic [SW-1:0]                  side,
  output logic                           out_valid,
  output logic [adsr_pkg::QUO_BITS:0]    quo,
  output logic [SW-1:0]                  out_side
);
  import adsr_pkg::*;

  logic                vld  [0:QUO_BITS];
  logic                cap  [0:QUO_BITS];
  logic [QUO_BITS-1:0] rem  [0:QUO_BITS];
  logic [QUO_BITS-1:0] low  [0:QUO_BITS];
  logic [QUO_BITS-1:0] q    [0:QUO_BITS];
  logic [QUO_BITS-1:0] dv   [0:QUO_BITS];
  logic [SW-1:0]       sd   [0:QUO_BITS];

  // quotient reaches the cap exactly when num >= den * 2^QUO_BITS;
  // otherwise the upper half is already below den
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    cap[0] <= num >= {den, {QUO_BITS{1'b0}}};
    rem[0] <= num[NUM_BITS-1 -: QUO_BITS];
    low[0] <= num[QUO_BITS-1:0];
    q[0]   <= '0;
    dv[0]  <= den;
    sd[0]  <= side;
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
    logic [QUO_BITS:0] trial;
    logic [QUO_BITS:0] diff;
    logic              ge;

    assign trial = {rem[k-1], low[k-1][QUO_BITS-1]};
    assign diff  = trial - {1'b0, dv[k-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      cap[k] <= cap[k-1];
      rem[k] <= ge ? diff[QUO_BITS-1:0] : trial[QUO_BITS-1:0];
      low[k] <= {low[k-1][QUO_BITS-2:0], 1'b0};
      q[k]   <= {q[k-1][QUO_BITS-2:0], ge};
      dv[k]  <= dv[k-1];
      sd[k]  <= sd[k-1];
    end
  end

  assign out_valid = vld[QUO_BITS];
  assign quo       = cap[QUO_BITS] ? QUO_CAP : {1'b0, q[QUO_BITS]};
  assign out_side  = sd[QUO_BITS];

endmodule

[sv/adsr_envelope_generator.sv]
// Top level of the linear ADSR envelope generator.
// Depends on adsr_pkg, adsr_div and adsr_envelope_generator_assert.svh.
//
//  port group              dir  handshake
//  start/busy/item         in   taken when start && !busy
//  result_valid/result     out  one-cycle strobe, no back-pressure
//  cfg_we/cfg_index/data   in   write on any edge with cfg_we
//
// One item per cycle; each result is registered through stages 1 to 7 and
// the two 25-stage dividers (held curve, release ramp).
// rst clears the valid bits and loads the register defaults; busy is high
// only during reset. Nothing ever stalls.
module adsr_envelope_generator #(
  parameter int TIME_BITS       = 32,
  parameter int LEVEL_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  adsr_pkg::item_t               item,
  output logic                          result_valid,
  output adsr_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [adsr_pkg::CFG_BITS-1:0] cfg_data
);
  import adsr_pkg::*;

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam logic [31:0] TMASK = 32'((64'(1) << TW) - 64'(1));
  localparam logic [25:0] LVL_MAX = 26'((64'(1) << (LEVEL_FRAC_BITS + 1)) - 64'(1));
  localparam int LAT = 7 + 2 * DIV_LAT;

  typedef enum logic [1:0] {SEG_ZERO, SEG_ATTACK, SEG_DECAY, SEG_SUSTAIN} seg_e;

  typedef struct packed {
    logic        held;
    logic [31:0] umag;
    logic        uneg;
    seg_e        seg;
    logic [15:0] base;
    logic        down;
  } side1_t;

  typedef struct packed {
    logic        held;
    logic        uneg;
    logic [15:0] h;
  } side2_t;

  // configuration registers
  logic [23:0] attack_ticks, decay_ticks, release_ticks;
  logic [15:0] start_level, sustain_level, silence_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks      <= 24'd1000;
      decay_ticks       <= 24'd4000;
      release_ticks     <= 24'd8000;
      start_level       <= 16'd32768;
      sustain_level     <= 16'd26214;
      silence_threshold <= 16'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:    attack_ticks      <= cfg_data;
        REG_DECAY:     decay_ticks       <= cfg_data;
        REG_RELEASE:   release_ticks     <= cfg_data;
        REG_START:     start_level       <= cfg_data[15:0];
        REG_SUSTAIN:   sustain_level     <= cfg_data[15:0];
        REG_THRESHOLD: silence_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [23:0] a_len, d_len, r_len;
  assign a_len = (attack_ticks  == '0) ? 24'd1 : attack_ticks;
  assign d_len = (decay_ticks   == '0) ? 24'd1 : decay_ticks;
  assign r_len = (release_ticks == '0) ? 24'd1 : release_ticks;

  assign busy = rst;

  // stage 1: tick differences
  logic [31:0] now_m, press_m, lift_m;
  assign now_m   = item.now_tick   & TMASK;
  assign press_m = item.press_tick & TMASK;
  assign lift_m  = item.lift_tick  & TMASK;

  logic        vld1, held1, uneg1;
  logic [32:0] t1;
  logic [31:0] umag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start && !busy;
    end
    held1 <= press_m > lift_m;
    t1    <= (press_m > lift_m) ? {1'b0, now_m} - {1'b0, press_m}
                                : {1'b0, lift_m} - {1'b0, press_m};
    uneg1 <= now_m < lift_m;
    umag1 <= (now_m < lift_m) ? lift_m - now_m : now_m - lift_m;
  end

  // stage 2: pick the segment of the held curve
  logic [31:0] ut;
  logic [24:0] ad_len;
  assign ut     = t1[31:0];
  assign ad_len = {1'b0, a_len} + {1'b0, d_len};

  logic        vld2;
  side1_t      sd2;
  logic [23:0] mag2, den2;
  logic [15:0] lvl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    sd2.held <= held1;
    sd2.umag <= umag1;
    sd2.uneg <= uneg1;
    if (t1[32]) begin
      sd2.seg  <= SEG_ZERO;
      sd2.base <= '0;
      sd2.down <= 1'b0;
      mag2     <= '0;
      lvl2     <= '0;
      den2     <= 24'd1;
    end else if (ut <= 32'(a_len)) begin
      sd2.seg  <= SEG_ATTACK;
      sd2.base <= '0;
      sd2.down <= 1'b0;
      mag2     <= ut[23:0];
      lvl2     <= start_level;
      den2     <= a_len;
    end else if (ut <= 32'(ad_len)) begin
      sd2.seg  <= SEG_DECAY;
      sd2.base <= start_level;
      sd2.down <= sustain_level < start_level;
      mag2     <= 24'(ut - 32'(a_len));
      lvl2     <= (sustain_level < start_level) ? start_level - sustain_level
                                                : sustain_level - start_level;
      den2     <= d_len;
    end else begin
      sd2.seg  <= SEG_SUSTAIN;
      sd2.base <= sustain_level;
      sd2.down <= 1'b0;
      mag2     <= '0;
      lvl2     <= '0;
      den2     <= 24'd1;
    end
  end

  // stage 3: ramp product
  logic                vld3;
  side1_t              sd3;
  logic [NUM_BITS-1:0] num3;
  logic [23:0]         den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    sd3  <= sd2;
    num3 <= NUM_BITS'(40'(mag2) * 40'(lvl2));
    den3 <= den2;
  end

  logic                  vld_d1;
  logic [QUO_BITS:0]     q_d1;
  logic [$bits(side1_t)-1:0] sdo1;
  side1_t                sd_d1;

  adsr_div #(.SW($bits(side1_t))) u_div_held (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld3),
    .num       (num3),
    .den       (den3),
    .side      (sd3),
    .out_valid (vld_d1),
    .quo       (q_d1),
    .out_side  (sdo1)
  );
  assign sd_d1 = side1_t'(sdo1);

  // stage 4: held level at the chosen moment
  logic        vld4;
  side2_t      sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld_d1;
    end
    sd4.held <= sd_d1.held;
    sd4.uneg <= sd_d1.uneg;
    case (sd_d1.seg)
      SEG_ATTACK:  sd4.h <= q_d1[15:0];
      SEG_DECAY:   sd4.h <= sd_d1.down ? sd_d1.base - q_d1[15:0]
                                       : sd_d1.base + q_d1[15:0];
      SEG_SUSTAIN: sd4.h <= sd_d1.base;
      default:     sd4.h <= '0;
    endcase
  end

  logic [31:0] umag4;
  always_ff @(posedge clk) begin
    umag4 <= sd_d1.umag;
  end

  // stage 5: release product
  logic                vld5;
  side2_t              sd5;
  logic [NUM_BITS-1:0] num5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
    sd5  <= sd4;
    num5 <= NUM_BITS'(48'(umag4) * 48'(sd4.h));
  end

  logic                  vld_d2;
  logic [QUO_BITS:0]     q_d2;
  logic [$bits(side2_t)-1:0] sdo2;
  side2_t                sd_d2;

  adsr_div #(.SW($bits(side2_t))) u_div_release (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld5),
    .num       (num5),
    .den       (r_len),
    .side      (sd5),
    .out_valid (vld_d2),
    .quo       (q_d2),
    .out_side  (sdo2)
  );
  assign sd_d2 = side2_t'(sdo2);

  // stage 6: signed amplitude
  logic        vld6, held6;
  logic [25:0] amp6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else begin
      vld6 <= vld_d2;
    end
    held6 <= sd_d2.held;
    if (sd_d2.held) begin
      amp6 <= 26'(sd_d2.h);
    end else if (sd_d2.uneg) begin
      amp6 <= 26'(sd_d2.h) + 26'(q_d2);
    end else begin
      amp6 <= 26'(sd_d2.h) - 26'(q_d2);
    end
  end

  // stage 7: threshold, saturation, output register
  logic        below;
  logic [25:0] amp_sat;
  assign below   = $signed(amp6) < $signed({10'b0, silence_threshold});
  assign amp_sat = below ? '0 : ((amp6 > LVL_MAX) ? LVL_MAX : amp6);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vld6;
    end
    result.level    <= amp_sat[15:0];
    result.finished <= !held6 && below;
  end

  `include "adsr_envelope_generator_assert.svh"

  `ADSR_ASSERT_IMP(a_fin_silent, result_valid && result.finished, result.level == '0, "finished item with nonzero level")
  `ADSR_ASSERT_IMP(a_latency, result_valid, $past(start && !busy, LAT), "result without a matching item")
  `ADSR_ASSERT_NXT(a_held_open, vld6 && held6, !result.finished, "held note reported finished")

endmodule

[tb/tb_adsr_envelope_generator.sv]
// Self-checking testbench for the linear ADSR envelope generator.
// Depends on adsr_pkg and the adsr_envelope_generator RTL.
`timescale 1ns / 1ps

module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam int LATENCY   = 57;
  localparam int WATCHDOG  = 20000;
  localparam longint LVL_CAP = (64'd1 << 16) - 1;
  localparam longint SCALE_LIM = 64'd1 << 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic result_valid;
  result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // shadow copy of the registers
  longint unsigned attack_len, decay_len, release_len;
  longint unsigned peak_lvl, sustain_lvl, thresh_lvl;

  result_t envelope_q[$];
  int errors = 0;
  int idle_cycles = 0;

  adsr_envelope_generator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned ramp_delta(longint unsigned mag,
      longint unsigned lvl, longint unsigned den);
    longint unsigned q, r, v;
    q = mag / den;
    r = mag % den;
    if (lvl == 0) return 0;
    if (q >= SCALE_LIM) return SCALE_LIM;
    v = lvl * q + (lvl * r) / den;
    return (v > SCALE_LIM) ? SCALE_LIM : v;
  endfunction

  function automatic longint held_level(longint t);
    longint unsigned a, d, ut;
    a = (attack_len == 0) ? 1 : attack_len;
    d = (decay_len == 0) ? 1 : decay_len;
    if (t < 0) return 0;
    ut = t;
    if (ut <= a) return ramp_delta(ut, peak_lvl, a);
    if (ut <= a + d) begin
      if (sustain_lvl >= peak_lvl)
        return peak_lvl + ramp_delta(ut - a, sustain_lvl - peak_lvl, d);
      return longint'(peak_lvl) - longint'(ramp_delta(ut - a, peak_lvl - sustain_lvl, d));
    end
    return sustain_lvl;
  endfunction

  function automatic result_t envelope_of(item_t it);
    longint unsigned now_t, press_t, lift_t, r;
    longint amp, h;
    result_t res;
    now_t = it.now_tick;
    press_t = it.press_tick;
    lift_t = it.lift_tick;
    res.finished = 1'b0;
    if (press_t > lift_t) begin
      amp = held_level(longint'(now_t) - longint'(press_t));
    end else begin
      h = held_level(longint'(lift_t) - longint'(press_t));
      r = (release_len == 0) ? 1 : release_len;
      if (now_t >= lift_t) amp = h - longint'(ramp_delta(now_t - lift_t, h, r));
      else amp = h + longint'(ramp_delta(lift_t - now_t, h, r));
      res.finished = (amp < longint'(thresh_lvl));
    end
    if (amp < longint'(thresh_lvl)) amp = 0;
    if (amp > LVL_CAP) amp = LVL_CAP;
    res.level = amp[15:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (envelope_q.size() == 0) begin
        $error("unexpected result level=%0d finished=%0b", result.level, result.finished);
        errors++;
      end else begin
        result_t exp_r;
        exp_r = envelope_q.pop_front();
        if (result.level !== exp_r.level) begin
          $error("level: expected %0d, got %0d", exp_r.level, result.level);
          errors++;
        end
        if (result.finished !== exp_r.finished) begin
          $error("finished: expected %0b, got %0b", exp_r.finished, result.finished);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("adsr_envelope_generator test failed");
      $finish;
    end
  end

  task automatic pause_random();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // one item; start left high when the next follows at once
  task automatic send_item(item_t it, bit gappy);
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    envelope_q.push_back(envelope_of(it));
    @(negedge clk);
    if (gappy && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      @(negedge clk);
      pause_random();
    end
  endtask

  // called at a falling edge right after the last item
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (envelope_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(cfg_reg_e idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_BITS-1:0];
    @(negedge clk);
    case (idx)
      REG_ATTACK:    attack_len  = val & 24'hFFFFFF;
      REG_DECAY:     decay_len   = val & 24'hFFFFFF;
      REG_RELEASE:   release_len = val & 24'hFFFFFF;
      REG_START:     peak_lvl    = val & 16'hFFFF;
      REG_SUSTAIN:   sustain_lvl = val & 16'hFFFF;
      REG_THRESHOLD: thresh_lvl  = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_envelope(longint unsigned a, longint unsigned d, longint unsigned r,
      longint unsigned s0, longint unsigned s1, longint unsigned th);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_RELEASE, r);
    write_reg(REG_START, s0);
    write_reg(REG_SUSTAIN, s1);
    write_reg(REG_THRESHOLD, th);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t make_item(logic [31:0] n, logic [31:0] p, logic [31:0] l);
    item_t it;
    it.now_tick = n;
    it.press_tick = p;
    it.lift_tick = l;
    return it;
  endfunction

  task automatic test_directed();
    logic [31:0] m;
    m = 32'hFFFF_FFFF;
    send_item(make_item(1500, 1000, 0), 0);          // held, in attack
    send_item(make_item(3000, 1000, 0), 0);          // held, in decay
    send_item(make_item(99999, 1000, 0), 0);         // held, sustain
    send_item(make_item(500, 1000, 0), 0);           // held, before press
    send_item(make_item(2000, 1000, 1000), 0);       // press equals lift
    send_item(make_item(3000, 1000, 2500), 0);       // release ramp
    send_item(make_item(1000, 1000, 9000), 0);       // before lift, upward
    send_item(make_item(m, 1000, 9000), 0);          // long after lift
    send_item(make_item(0, 0, m), 0);                // before lift, far
    send_item(make_item(m, m, 0), 0);                // extremes
    send_item(make_item(0, m, 0), 0);
    send_item(make_item(m, 0, m), 0);
    send_item(make_item(m, 1, 0), 0);
    drain();
    // zero lengths act as one; rising decay; zero threshold
    set_envelope(0, 0, 0, 100, 32768, 0);
    send_item(make_item(10, 9, 0), 0);
    send_item(make_item(11, 9, 0), 0);
    send_item(make_item(12, 9, 0), 0);
    send_item(make_item(20, 9, 30), 0);
    send_item(make_item(0, 9, 30), 0);
    drain();
    // maximum lengths; threshold equal to the start level
    set_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32768, 0, 32768);
    send_item(make_item(32'h0100_0000, 0, 32'h0100_0000), 0);
    send_item(make_item(32'h00FF_FFFF, 0, 1), 0);
    send_item(make_item(32'h0200_0000, 1, 0), 0);
    drain();
  endtask

  function automatic logic [31:0] rand_tick();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 64);
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  // mostly realistic notes relative to press, plus raw noise
  task automatic test_random_notes(int count);
    logic [31:0] p, l, n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        p = $urandom(); l = $urandom(); n = $urandom();
      end else begin
        p = $urandom_range(0, 32'h7FFF_FFFF);
        l = ($urandom_range(0, 2) == 0) ? p - $urandom_range(0, 100) : p + rand_tick();
        n = ($urandom_range(0, 4) == 0) ? p - rand_tick() : p + rand_tick();
      end
      send_item(make_item(n, p, l), 1);
    end
    drain();
  endtask

  task automatic random_config();
    longint unsigned a, d, r;
    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 5000);
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 20000);
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 40000);
    set_envelope(a, d, r, $urandom_range(0, 32768), $urandom_range(0, 32768),
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32768) : $urandom_range(0, 200));
  endtask

  initial begin
    attack_len = 1000; decay_len = 4000; release_len = 8000;
    peak_lvl = 32768; sustain_lvl = 26214; thresh_lvl = 33;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    for (int k = 0; k < 8; k++) begin
      random_config();
      test_random_notes(210);
    end
    if (errors == 0) $display("adsr_envelope_generator test passed");
    else $display("adsr_envelope_generator test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/adsr_pkg.sv
sv/adsr_div.sv
sv/adsr_envelope_generator.sv
tb/tb_adsr_envelope_generator.sv
